// ===== design/pvsd_pkg.sv =====
package pvsd_pkg;

    // Sample and window sizing
    localparam int ACC_W      = 16;
    localparam int AVG_TAPS   = 5;
    localparam int TIME_BITS  = 40;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
    localparam int FILL_W     = $clog2(AVG_TAPS + 1);
    localparam int MAG_W      = ACC_W - 1 + FILL_W;
    localparam int SUM_W      = MAG_W + 1;

    // Reciprocal divide: floor(m / d) == (m * ceil(2^K / d)) >> K for m below 2^MAG_W
    localparam int RECIP_K    = MAG_W + FILL_W;
    localparam int RECIP_W    = RECIP_K + 1;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int RECIP_IDX  = 17;
    localparam int RECIP_IW   = 5;
    localparam int RECIP_ONE  = 2 ** RECIP_K;

    localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_IDX] = '{
        RECIP_W'(0),
        RECIP_W'((RECIP_ONE + 0) / 1),
        RECIP_W'((RECIP_ONE + 1) / 2),
        RECIP_W'((RECIP_ONE + 2) / 3),
        RECIP_W'((RECIP_ONE + 3) / 4),
        RECIP_W'((RECIP_ONE + 4) / 5),
        RECIP_W'((RECIP_ONE + 5) / 6),
        RECIP_W'((RECIP_ONE + 6) / 7),
        RECIP_W'((RECIP_ONE + 7) / 8),
        RECIP_W'((RECIP_ONE + 8) / 9),
        RECIP_W'((RECIP_ONE + 9) / 10),
        RECIP_W'((RECIP_ONE + 10) / 11),
        RECIP_W'((RECIP_ONE + 11) / 12),
        RECIP_W'((RECIP_ONE + 12) / 13),
        RECIP_W'((RECIP_ONE + 13) / 14),
        RECIP_W'((RECIP_ONE + 14) / 15),
        RECIP_W'((RECIP_ONE + 15) / 16)
    };

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Port sizing
    localparam int IN_USER_W   = 2;
    localparam int IN_DATA_W   = ((ACC_W + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 + COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Sample source codes
    localparam logic [IN_USER_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [IN_USER_W-1:0] KIND_LINEAR  = 2'd1;
    localparam logic [IN_USER_W-1:0] KIND_GRAVITY = 2'd2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_PEAK    = 3'd0,
        CFG_DOWN_PEAK  = 3'd1,
        CFG_MIN_SWING  = 3'd2,
        CFG_MIN_PERIOD = 3'd3,
        CFG_MAX_PERIOD = 3'd4,
        CFG_MIN_GAP    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic        [14:0] up_peak_level;
        logic signed [15:0] down_peak_level;
        logic        [15:0] min_swing;
        logic        [15:0] min_peak_period_ms;
        logic        [15:0] max_peak_period_ms;
        logic        [15:0] min_step_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic signed [ACC_W-1:0]     z;
        logic        [TIME_BITS-1:0] t;
    } t_qword;

    typedef struct packed {
        logic               step_detected;
        logic               cycle_evaluated;
        logic [COUNT_W-1:0] step_count;
    } t_result;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_SUM,
        FE_MUL,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_TRACK,
        BE_PERIOD,
        BE_PCHECK,
        BE_GCHECK,
        BE_EMIT
    } t_be_state;

    typedef enum logic [1:0] {
        PH_PEAK   = 2'd0,
        PH_VALLEY = 2'd1,
        PH_RISE   = 2'd2
    } t_phase;

endpackage

// ===== design/pvsd_front.sv =====
module pvsd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pvsd_pkg::IN_USER_W-1:0]      i_kind,
    input  logic signed [pvsd_pkg::ACC_W-1:0]   i_accel,
    input  logic [pvsd_pkg::TIME_BITS-1:0]      i_time,
    output logic                                o_push_valid,
    input  logic                                i_push_ready,
    output pvsd_pkg::t_qword                    o_push_word
);

    pvsd_pkg::t_fe_state r_state, n_state;

    logic signed [pvsd_pkg::ACC_W-1:0]  r_slot [2][pvsd_pkg::AVG_TAPS];
    logic [pvsd_pkg::IDX_W-1:0]         r_head [2];
    logic [pvsd_pkg::FILL_W-1:0]        r_fill [2];
    logic                               r_src;
    logic [pvsd_pkg::TIME_BITS-1:0]     r_time;
    logic [pvsd_pkg::IDX_W-1:0]         r_idx;
    logic signed [pvsd_pkg::SUM_W-1:0]  r_acc;
    logic [pvsd_pkg::PROD_W-1:0]        r_prod;
    logic                               r_neg;

    logic                               w_accept;
    logic                               w_active;
    logic                               w_src;
    logic [pvsd_pkg::FILL_W-1:0]        w_fill_cur;
    logic signed [pvsd_pkg::SUM_W-1:0]  w_abs;
    logic [pvsd_pkg::MAG_W-1:0]         w_mag;
    logic [pvsd_pkg::ACC_W-1:0]         w_quot;

    // Decode the source of the incoming word
    assign w_active   = (i_kind == pvsd_pkg::KIND_LINEAR) || (i_kind == pvsd_pkg::KIND_GRAVITY);
    assign w_src      = (i_kind == pvsd_pkg::KIND_GRAVITY);
    assign w_accept   = i_valid && (r_state == pvsd_pkg::FE_IDLE);
    assign w_fill_cur = r_fill[r_src];
    assign w_abs      = r_acc[pvsd_pkg::SUM_W-1] ? -r_acc : r_acc;
    assign w_mag      = w_abs[pvsd_pkg::MAG_W-1:0];
    assign w_quot     = r_prod[pvsd_pkg::RECIP_K +: pvsd_pkg::ACC_W];

    // Hand the averaged sample on to the queue
    assign o_push_word.z = r_neg ? -w_quot : w_quot;
    assign o_push_word.t = r_time;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvsd_pkg::FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_push_valid = 1'b0;
        case (r_state)
            pvsd_pkg::FE_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = w_active ? pvsd_pkg::FE_SUM : pvsd_pkg::FE_PUSH;
                end
            end
            pvsd_pkg::FE_SUM: begin
                if (r_idx == pvsd_pkg::IDX_W'(pvsd_pkg::AVG_TAPS - 1)) begin
                    n_state = pvsd_pkg::FE_MUL;
                end
            end
            pvsd_pkg::FE_MUL: begin
                n_state = pvsd_pkg::FE_PUSH;
            end
            pvsd_pkg::FE_PUSH: begin
                o_push_valid = 1'b1;
                if (i_push_ready) begin
                    n_state = pvsd_pkg::FE_IDLE;
                end
            end
            default: begin
                n_state = pvsd_pkg::FE_IDLE;
            end
        endcase
    end

    // Window pointers and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
        end else if (w_accept && w_active) begin
            if (r_head[w_src] == pvsd_pkg::IDX_W'(pvsd_pkg::AVG_TAPS - 1)) begin
                r_head[w_src] <= '0;
            end else begin
                r_head[w_src] <= r_head[w_src] + 1'b1;
            end
            if (r_fill[w_src] != pvsd_pkg::FILL_W'(pvsd_pkg::AVG_TAPS)) begin
                r_fill[w_src] <= r_fill[w_src] + 1'b1;
            end
        end
    end

    // Store the sample, sum the filled taps one a cycle, then scale by the reciprocal
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_src  <= w_src;
            r_time <= i_time;
            r_idx  <= '0;
            r_acc  <= '0;
            r_prod <= '0;
            r_neg  <= 1'b0;
            if (w_active) begin
                r_slot[w_src][r_head[w_src]] <= i_accel;
            end
        end
        if (r_state == pvsd_pkg::FE_SUM) begin
            r_idx <= r_idx + 1'b1;
            if (pvsd_pkg::FILL_W'(r_idx) < w_fill_cur) begin
                r_acc <= r_acc + pvsd_pkg::SUM_W'(r_slot[r_src][r_idx]);
            end
        end
        if (r_state == pvsd_pkg::FE_MUL) begin
            r_prod <= w_mag * pvsd_pkg::RECIP_TABLE[pvsd_pkg::RECIP_IW'(w_fill_cur)];
            r_neg  <= r_acc[pvsd_pkg::SUM_W-1];
        end
    end

endmodule

// ===== design/pvsd_queue.sv =====
module pvsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  pvsd_pkg::t_qword i_push_word,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output pvsd_pkg::t_qword o_pop_word
);

    pvsd_pkg::t_qword             r_mem [pvsd_pkg::QUEUE_DEPTH];
    logic [pvsd_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [pvsd_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [pvsd_pkg::QCNT_W-1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_count != pvsd_pkg::QCNT_W'(pvsd_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop_ready && o_pop_valid;
    assign o_pop_word   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                if (r_wr_ptr == pvsd_pkg::QPTR_W'(pvsd_pkg::QUEUE_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end
            if (w_pop) begin
                if (r_rd_ptr == pvsd_pkg::QPTR_W'(pvsd_pkg::QUEUE_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

endmodule

// ===== design/pvsd_back.sv =====
module pvsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pvsd_pkg::t_cfg    i_cfg,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  pvsd_pkg::t_qword  i_word,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output pvsd_pkg::t_result o_res
);

    localparam int TB = pvsd_pkg::TIME_BITS;
    localparam int AW = pvsd_pkg::ACC_W;

    pvsd_pkg::t_be_state r_state, n_state;
    pvsd_pkg::t_phase    r_phase, n_phase;

    logic signed [AW-1:0]            r_peak, n_peak;
    logic signed [AW-1:0]            r_valley, n_valley;
    logic [TB-1:0]                   r_up_time, n_up_time;
    logic [TB-1:0]                   r_valley_time, n_valley_time;
    logic [TB-1:0]                   r_prev_up;
    logic                            r_first;
    logic [TB-1:0]                   r_last_step;
    logic [pvsd_pkg::COUNT_W-1:0]    r_count, n_count;

    logic signed [AW-1:0]            r_z;
    logic [TB-1:0]                   r_t;
    logic                            r_done, n_done;
    logic [TB:0]                     r_diff;
    logic                            r_period_ok;
    logic                            r_swing_ok;
    logic                            r_valid;
    logic                            r_out_valid;
    pvsd_pkg::t_result               r_out;

    logic                            w_out_free;
    logic                            w_emit;
    logic                            w_step;
    logic                            w_pair_first;
    logic [TB-1:0]                   w_later;
    logic [TB-1:0]                   w_earlier;
    logic signed [AW:0]              w_swing;
    logic                            w_above_up;
    logic                            w_below_down;
    logic [TB-1:0]                   w_span;
    logic                            w_span_ok;

    assign w_out_free  = !r_out_valid || i_res_ready;
    assign w_emit      = (r_state == pvsd_pkg::BE_EMIT) && w_out_free;
    assign w_step      = r_done && r_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Peak-to-peak span: valley difference on the first cycle or with no earlier peak
    assign w_pair_first = r_first || (r_prev_up == '0);
    assign w_later      = w_pair_first ? r_valley_time : r_up_time;
    assign w_earlier    = w_pair_first ? r_up_time : r_prev_up;
    assign w_swing      = (AW + 1)'(r_peak) - (AW + 1)'(r_valley);
    assign w_span       = r_diff[TB-1:0];
    assign w_span_ok    = !r_diff[TB]
                          && (w_span >= TB'(i_cfg.min_peak_period_ms))
                          && (w_span <= TB'(i_cfg.max_peak_period_ms));

    assign w_above_up   = $signed({r_z[AW-1], r_z}) > $signed({2'b00, i_cfg.up_peak_level});
    assign w_below_down = r_z < i_cfg.down_peak_level;

    // Tracker next values for one sample
    always_comb begin
        n_phase       = r_phase;
        n_peak        = r_peak;
        n_valley      = r_valley;
        n_up_time     = r_up_time;
        n_valley_time = r_valley_time;
        n_done        = 1'b0;
        case (r_phase)
            pvsd_pkg::PH_PEAK: begin
                if (w_above_up) begin
                    if (r_z < r_peak) begin
                        n_phase   = pvsd_pkg::PH_VALLEY;
                        n_up_time = r_t;
                        n_peak    = '0;
                    end else begin
                        n_peak = r_z;
                    end
                end
            end
            pvsd_pkg::PH_VALLEY: begin
                if (r_z > r_peak) begin
                    n_peak = r_z;
                end else if (w_below_down) begin
                    if (r_z > r_valley) begin
                        n_phase       = pvsd_pkg::PH_RISE;
                        n_valley_time = r_t;
                    end else begin
                        n_valley = r_z;
                    end
                end
            end
            pvsd_pkg::PH_RISE: begin
                if (r_z < r_valley) begin
                    n_valley      = r_z;
                    n_valley_time = r_t;
                end else if (!r_z[AW-1]) begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_phase = pvsd_pkg::PH_PEAK;
            end
        endcase
    end

    // Saturating step count after this sample
    always_comb begin
        n_count = r_count;
        if (w_step && (r_count != {pvsd_pkg::COUNT_W{1'b1}})) begin
            n_count = r_count + 1'b1;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvsd_pkg::BE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one sample: track, check a finished cycle, emit
    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        case (r_state)
            pvsd_pkg::BE_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_state = pvsd_pkg::BE_TRACK;
                end
            end
            pvsd_pkg::BE_TRACK: begin
                n_state = n_done ? pvsd_pkg::BE_PERIOD : pvsd_pkg::BE_EMIT;
            end
            pvsd_pkg::BE_PERIOD: begin
                n_state = pvsd_pkg::BE_PCHECK;
            end
            pvsd_pkg::BE_PCHECK: begin
                n_state = pvsd_pkg::BE_GCHECK;
            end
            pvsd_pkg::BE_GCHECK: begin
                n_state = pvsd_pkg::BE_EMIT;
            end
            pvsd_pkg::BE_EMIT: begin
                if (w_out_free) begin
                    n_state = pvsd_pkg::BE_IDLE;
                end
            end
            default: begin
                n_state = pvsd_pkg::BE_IDLE;
            end
        endcase
    end

    // Tracker and step state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pvsd_pkg::PH_PEAK;
            r_peak        <= '0;
            r_valley      <= '0;
            r_up_time     <= '0;
            r_valley_time <= '0;
            r_prev_up     <= '0;
            r_first       <= 1'b1;
            r_last_step   <= '0;
            r_count       <= '0;
        end else if (r_state == pvsd_pkg::BE_TRACK) begin
            r_phase       <= n_phase;
            r_peak        <= n_peak;
            r_valley      <= n_valley;
            r_up_time     <= n_up_time;
            r_valley_time <= n_valley_time;
        end else if (w_emit) begin
            r_count <= n_count;
            if (r_done) begin
                if (r_valid) begin
                    r_last_step <= r_t;
                end
                r_prev_up <= r_up_time;
                r_first   <= 1'b0;
                r_phase   <= pvsd_pkg::PH_PEAK;
                r_peak    <= '0;
                r_valley  <= '0;
            end
        end
    end

    // Working registers of the checks
    always_ff @(posedge i_clk) begin
        case (r_state)
            pvsd_pkg::BE_IDLE: begin
                r_z <= i_word.z;
                r_t <= i_word.t;
            end
            pvsd_pkg::BE_TRACK: begin
                r_done  <= n_done;
                r_valid <= 1'b0;
            end
            pvsd_pkg::BE_PERIOD: begin
                r_diff     <= {1'b0, w_later} - {1'b0, w_earlier};
                r_swing_ok <= w_swing >= $signed({1'b0, i_cfg.min_swing});
            end
            pvsd_pkg::BE_PCHECK: begin
                r_period_ok <= w_span_ok;
                r_diff      <= {1'b0, r_t} - {1'b0, r_last_step};
            end
            pvsd_pkg::BE_GCHECK: begin
                r_valid <= r_period_ok && r_swing_ok
                           && ((r_last_step == '0)
                               || (!r_diff[TB] && (w_span >= TB'(i_cfg.min_step_gap_ms))));
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.step_detected   <= w_step;
            r_out.cycle_evaluated <= r_done;
            r_out.step_count      <= n_count;
        end
    end

endmodule

// ===== design/peak_valley_step_detector.sv =====
// Each accepted word gives one result after passing the front end, the queue and the back
// end; the back end adds the period and gap checks when a peak/valley cycle completes.
// The front end takes one sample at a time, summing one tap a cycle while it averages,
// and holds a finished sample while the queue is full; absent samples skip the sum.
// The back end handles one sample at a time and runs behind a two-word queue.
// Reset is synchronous, active low: config returns to defaults; window fill counts,
// tracker state and the step count clear at once, with no clearing pass.
module peak_valley_step_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: accel_z [15:0], timestamp_ms [55:16]
    input  logic [pvsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: kind [1:0]
    input  logic [pvsd_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: step_detected [0], cycle_evaluated [1], step_count [33:2], zero pad above
    output logic [pvsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pvsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pvsd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pvsd_pkg::t_cfg    r_cfg;
    pvsd_pkg::t_qword  w_push_word;
    pvsd_pkg::t_qword  w_pop_word;
    pvsd_pkg::t_result w_res;
    logic              w_push_valid;
    logic              w_push_ready;
    logic              w_pop_valid;
    logic              w_pop_ready;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_peak_level      <= 15'd307;
            r_cfg.down_peak_level    <= -16'sd256;
            r_cfg.min_swing          <= 16'd512;
            r_cfg.min_peak_period_ms <= 16'd250;
            r_cfg.max_peak_period_ms <= 16'd1500;
            r_cfg.min_step_gap_ms    <= 16'd300;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pvsd_pkg::CFG_UP_PEAK:    r_cfg.up_peak_level      <= i_cfg_data[14:0];
                pvsd_pkg::CFG_DOWN_PEAK:  r_cfg.down_peak_level    <= i_cfg_data;
                pvsd_pkg::CFG_MIN_SWING:  r_cfg.min_swing          <= i_cfg_data;
                pvsd_pkg::CFG_MIN_PERIOD: r_cfg.min_peak_period_ms <= i_cfg_data;
                pvsd_pkg::CFG_MAX_PERIOD: r_cfg.max_peak_period_ms <= i_cfg_data;
                pvsd_pkg::CFG_MIN_GAP:    r_cfg.min_step_gap_ms    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Averaging front end
    pvsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_accel      (s_axis_tdata[pvsd_pkg::ACC_W-1:0]),
        .i_time       (s_axis_tdata[pvsd_pkg::ACC_W +: pvsd_pkg::TIME_BITS]),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_word  (w_push_word)
    );

    // Decoupling queue
    pvsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_word  (w_push_word),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_word   (w_pop_word)
    );

    // Peak tracker and step checks
    pvsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_word      (w_pop_word),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = pvsd_pkg::OUT_DATA_W'({w_res.step_count, w_res.cycle_evaluated,
                                                 w_res.step_detected});

    // The front end goes busy once it has taken a word
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("front end ready straight after taking a word");

    // A step is only reported on an evaluated cycle
    a_step_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("step reported without a completed cycle");

    // A word refused by a full queue is held by the front end
    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && !w_push_ready) |=> (w_push_valid && $stable(w_push_word)))
        else $error("front end dropped a word the queue refused");

endmodule
